// ----- hdl/bsac_pkg.sv -----
package bsac_pkg;

    localparam int DIM_W     = 13;
    localparam int SUM_W     = 32;
    localparam int CNT_W     = 2 * DIM_W;
    localparam int ACC_W     = 10;
    localparam int CFG_IDX_W = 3;
    localparam int SEL_W     = 4;
    localparam int NUM_REGS  = 6;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_STRIP_ROWS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_STRIP_START = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_STRIP_COLS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_STRIP_START  = 3'd5;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       frame_start;
    } pixel_t;

    typedef struct packed {
        logic [7:0] avg_red;
        logic [7:0] avg_green;
        logic [7:0] avg_blue;
        logic [7:0] avg_alpha;
    } result_t;

    typedef struct packed {
        logic             accept;
        logic             load_counts;
        logic             div_start;
        logic             acc_add;
        logic             publish;
        logic [SEL_W-1:0] sel;
    } cmd_t;

    typedef struct packed {
        logic last_pixel;
        logic div_busy;
        logic div_done;
        logic res_busy;
    } status_t;

endpackage

// ----- hdl/bsac_div.sv -----
module bsac_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [bsac_pkg::SUM_W-1:0] dividend,
    input  logic [bsac_pkg::CNT_W-1:0] divisor,
    output logic                       busy,
    output logic                       done,
    output logic [bsac_pkg::SUM_W-1:0] quotient
);
    import bsac_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  dsr_reg, dsr_next;
    logic [CNT_W:0]    partial;
    logic [CNT_W:0]    trial;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign partial = {rem_reg, quo_reg[SUM_W-1]};
    assign trial   = partial - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (partial >= {1'b0, dsr_reg})
            begin
                rem_next = trial[CNT_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = partial[CNT_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- hdl/bsac_datapath.sv -----
module bsac_datapath #(
    parameter int MAX_DIM = 4096
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bsac_pkg::cmd_t                 cmd,
    output bsac_pkg::status_t              status,
    input  bsac_pkg::pixel_t               pix,
    output logic                           res_valid,
    input  logic                           res_stall,
    output bsac_pkg::result_t              res,
    input  logic                           cfg_we,
    input  logic [bsac_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bsac_pkg::DIM_W-1:0]     cfg_data
);
    import bsac_pkg::*;

    localparam int DIM_LIM = (MAX_DIM < (2 ** DIM_W - 1)) ? MAX_DIM : (2 ** DIM_W - 1);
    localparam int CW      = $clog2(DIM_LIM);

    logic [DIM_W-1:0] cfg_reg [NUM_REGS];
    logic [CW-1:0]    col_reg, col_next;
    logic [CW-1:0]    row_reg, row_next;
    logic [SUM_W-1:0] sum_reg [16];
    logic [SUM_W-1:0] sum_next [16];
    logic [CNT_W-1:0] cnt_reg [4];
    logic [CNT_W-1:0] cnt_next [4];
    logic [ACC_W-1:0] acc_reg [4];
    logic [ACC_W-1:0] acc_next [4];
    logic             res_valid_reg, res_valid_next;
    result_t          res_reg, res_next;

    logic [DIM_W-1:0] w_eff, h_eff, top_c, bot_c, left_c, right_c;
    logic [CW-1:0]    col_eff, row_eff;
    logic [DIM_W:0]   col_p1, row_p1;
    logic             col_wrap, row_wrap;
    logic [3:0]       member;
    logic [7:0]       chan [4];
    logic [CNT_W-1:0] prod [4];

    logic             div_busy, div_done;
    logic [SUM_W-1:0] quotient;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (32'(v) > MAX_DIM)
            r = DIM_W'(MAX_DIM);
        else
            r = v;
        return r;
    endfunction

    assign w_eff   = eff_dim(cfg_reg[REG_IMAGE_WIDTH]);
    assign h_eff   = eff_dim(cfg_reg[REG_IMAGE_HEIGHT]);
    assign top_c   = (cfg_reg[REG_TOP_STRIP_ROWS] > h_eff) ? h_eff
                                                           : cfg_reg[REG_TOP_STRIP_ROWS];
    assign bot_c   = (cfg_reg[REG_BOTTOM_STRIP_START] > h_eff) ? h_eff
                                                               : cfg_reg[REG_BOTTOM_STRIP_START];
    assign left_c  = (cfg_reg[REG_LEFT_STRIP_COLS] > w_eff) ? w_eff
                                                            : cfg_reg[REG_LEFT_STRIP_COLS];
    assign right_c = (cfg_reg[REG_RIGHT_STRIP_START] > w_eff) ? w_eff
                                                              : cfg_reg[REG_RIGHT_STRIP_START];

    // frame start places the pixel at the origin
    assign col_eff  = pix.frame_start ? '0 : col_reg;
    assign row_eff  = pix.frame_start ? '0 : row_reg;
    assign col_p1   = (DIM_W + 1)'(col_eff) + 1'b1;
    assign row_p1   = (DIM_W + 1)'(row_eff) + 1'b1;
    assign col_wrap = col_p1 >= {1'b0, w_eff};
    assign row_wrap = row_p1 >= {1'b0, h_eff};

    assign member[0] = DIM_W'(row_eff) <  top_c;
    assign member[1] = DIM_W'(col_eff) >= right_c;
    assign member[2] = DIM_W'(row_eff) >= bot_c;
    assign member[3] = DIM_W'(col_eff) <  left_c;

    assign chan[0] = pix.red;
    assign chan[1] = pix.green;
    assign chan[2] = pix.blue;
    assign chan[3] = pix.alpha;

    assign prod[0] = top_c * w_eff;
    assign prod[1] = h_eff * (w_eff - right_c);
    assign prod[2] = (h_eff - bot_c) * w_eff;
    assign prod[3] = left_c * h_eff;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        for (int i = 0; i < 16; i++)
            sum_next[i] = sum_reg[i];
        if (cmd.accept)
        begin
            for (int i = 0; i < 16; i++)
            begin
                sum_next[i] = pix.frame_start ? '0 : sum_reg[i];
                if (member[i / 4])
                    sum_next[i] = sum_next[i] + SUM_W'(chan[i % 4]);
            end
            if (!col_wrap)
            begin
                col_next = CW'(col_p1);
                row_next = row_eff;
            end
            else
            begin
                col_next = '0;
                row_next = row_wrap ? '0 : CW'(row_p1);
            end
        end
        else if (cmd.publish)
        begin
            for (int i = 0; i < 16; i++)
                sum_next[i] = '0;
            col_next = '0;
            row_next = '0;
        end
    end

    always_comb
    begin
        for (int s = 0; s < 4; s++)
        begin
            cnt_next[s] = cnt_reg[s];
            acc_next[s] = acc_reg[s];
        end
        if (cmd.load_counts)
        begin
            for (int s = 0; s < 4; s++)
            begin
                cnt_next[s] = (prod[s] == '0) ? CNT_W'(1) : prod[s];
                acc_next[s] = '0;
            end
        end
        else if (cmd.acc_add)
            acc_next[cmd.sel[1:0]] = acc_reg[cmd.sel[1:0]] + quotient[ACC_W-1:0];
    end

    always_comb
    begin
        res_next       = res_reg;
        res_valid_next = res_valid_reg && res_stall;
        if (cmd.publish)
        begin
            res_valid_next     = 1'b1;
            res_next.avg_red   = acc_reg[0][ACC_W-1:2];
            res_next.avg_green = acc_reg[1][ACC_W-1:2];
            res_next.avg_blue  = acc_reg[2][ACC_W-1:2];
            res_next.avg_alpha = acc_reg[3][ACC_W-1:2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[REG_IMAGE_WIDTH]        <= DIM_W'(1);
            cfg_reg[REG_IMAGE_HEIGHT]       <= DIM_W'(1);
            cfg_reg[REG_TOP_STRIP_ROWS]     <= '0;
            cfg_reg[REG_BOTTOM_STRIP_START] <= '0;
            cfg_reg[REG_LEFT_STRIP_COLS]    <= '0;
            cfg_reg[REG_RIGHT_STRIP_START]  <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < 16; i++)
                sum_reg[i] <= '0;
        end
        else
        begin
            if (cfg_we && (32'(cfg_index) < NUM_REGS))
                cfg_reg[cfg_index] <= cfg_data;
            col_reg       <= col_next;
            row_reg       <= row_next;
            res_valid_reg <= res_valid_next;
            for (int i = 0; i < 16; i++)
                sum_reg[i] <= sum_next[i];
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        for (int s = 0; s < 4; s++)
        begin
            cnt_reg[s] <= cnt_next[s];
            acc_reg[s] <= acc_next[s];
        end
    end

    bsac_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sum_reg[cmd.sel]),
        .divisor  (cnt_reg[cmd.sel[3:2]]),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quotient)
    );

    assign status.last_pixel = col_wrap && row_wrap;
    assign status.div_busy   = div_busy;
    assign status.div_done   = div_done;
    assign status.res_busy   = res_valid_reg && res_stall;

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_publish_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> !(res_valid_reg && res_stall))
        else $error("result overwritten while stalled");

    a_publish_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |=> res_valid_reg)
        else $error("published result not presented");

    a_publish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |=> (sum_reg[0] == '0) && (sum_reg[15] == '0)
                        && (col_reg == '0) && (row_reg == '0))
        else $error("frame state not cleared after result");

endmodule

// ----- hdl/bsac_ctrl.sv -----
module bsac_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pix_valid,
    output logic              pix_stall,
    input  bsac_pkg::status_t status,
    output bsac_pkg::cmd_t    cmd
);
    import bsac_pkg::*;

    typedef enum logic [2:0] {
        S_ACCUM,
        S_COUNT,
        S_DIV_GO,
        S_DIV_WAIT,
        S_PUBLISH
    } state_t;

    state_t           state_reg, state_next;
    logic [SEL_W-1:0] sel_reg, sel_next;

    always_comb
    begin
        state_next      = state_reg;
        sel_next        = sel_reg;
        cmd.accept      = 1'b0;
        cmd.load_counts = 1'b0;
        cmd.div_start   = 1'b0;
        cmd.acc_add     = 1'b0;
        cmd.publish     = 1'b0;
        cmd.sel         = sel_reg;
        case (state_reg)
            S_ACCUM:
            begin
                cmd.accept = pix_valid;
                if (pix_valid && status.last_pixel)
                    state_next = S_COUNT;
            end
            S_COUNT:
            begin
                cmd.load_counts = 1'b1;
                sel_next        = '0;
                state_next      = S_DIV_GO;
            end
            S_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.acc_add = 1'b1;
                    sel_next    = sel_reg + 1'b1;
                    state_next  = (sel_reg == '1) ? S_PUBLISH : S_DIV_GO;
                end
            end
            S_PUBLISH:
            begin
                if (!status.res_busy)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_ACCUM;
                end
            end
            default:
                state_next = S_ACCUM;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_ACCUM;
            sel_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    assign pix_stall = (state_reg != S_ACCUM);

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !status.div_busy)
        else $error("divider started while busy");

    a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> (state_reg == S_DIV_WAIT))
        else $error("divider finished outside wait state");

    a_last_to_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && status.last_pixel) |=> (state_reg == S_COUNT) && pix_stall)
        else $error("end of frame not followed by division");

endmodule

// ----- hdl/border_strip_average_color_core.sv -----
// Channel    Direction  Handshake              Payload
// pix        in         pix_valid / pix_stall  pixel_t: red, green, blue, alpha, frame_start
// res        out        res_valid / res_stall  result_t: avg_red .. avg_alpha
// cfg        in         cfg_we (no wait)       cfg_index selects register, cfg_data 13 bits
//
// A transaction completes when valid is high and stall is low. Pixels are taken one
// per cycle while a frame streams in.
// After the last pixel of a frame the pixel side stalls while the strip counts are loaded,
// a shared radix-2 divider works through each strip/channel sum in turn (start, 32 quotient
// bits, accumulate) and the result is published. Publishing waits while a previous result
// is still stalled; reset sets a 1x1 geometry and clears sums, position and control state.
module border_strip_average_color_core #(
    parameter int MAX_DIM = 4096
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           pix_valid,
    output logic                           pix_stall,
    input  bsac_pkg::pixel_t               pix,
    output logic                           res_valid,
    input  logic                           res_stall,
    output bsac_pkg::result_t              res,
    input  logic                           cfg_we,
    input  logic [bsac_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bsac_pkg::DIM_W-1:0]     cfg_data
);
    import bsac_pkg::*;

    // command and status between the sequencer and the datapath
    cmd_t    cmd;
    status_t status;

    // sequencer: accumulate, load counts, divide each sum, publish
    bsac_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath: registers, position counters, strip sums, divider, output register
    bsac_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .pix       (pix),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

    import bsac_pkg::*;

    // Geometry limit handed to the block; must match the shadow model below.
    localparam int FRAME_DIM_MAX    = 4096;
    // Settling time the block may still need after its last result: sixteen divides,
    // the strip count load and the publish, plus margin.
    localparam int DIVIDE_LATENCY   = 16 * 34 + 2 + 60;
    localparam int RANDOM_ITEMS     = 1200;
    localparam int LONG_HOLD_CYCLES = 3000;
    localparam int WATCHDOG_NS      = 20_000_000;

    // Strip order used by the shadow sums: index is strip * 4 + channel.
    localparam int STRIP_TOP    = 0;
    localparam int STRIP_RIGHT  = 1;
    localparam int STRIP_BOTTOM = 2;
    localparam int STRIP_LEFT   = 3;
    localparam int NUM_STRIPS   = 4;
    localparam int NUM_CHANNELS = 4;

    // Register indexes past the end of the map; writes there must be dropped.
    localparam logic [CFG_IDX_W-1:0] SPARE_INDEX_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] SPARE_INDEX_HI = 3'd7;

    // Receiver stall behaviors, chosen per epoch.
    localparam int STALL_NONE     = 0;
    localparam int STALL_LIGHT    = 1;
    localparam int STALL_PERIODIC = 2;
    localparam int STALL_HEAVY    = 3;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 pix_valid = 1'b0;
    logic                 pix_stall;
    pixel_t               pix       = '0;
    logic                 res_valid;
    logic                 res_stall = 1'b0;
    result_t              res;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data  = '0;

    border_strip_average_color_core #(
        .MAX_DIM(FRAME_DIM_MAX)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .pix_valid(pix_valid),
        .pix_stall(pix_stall),
        .pix      (pix),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res      (res),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow model of the block: register copy, strip sums and raster
    // position. Updated on every accepted pixel transaction.
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] shadow_regs [NUM_REGS];
    logic [31:0]      strip_sum [NUM_STRIPS * NUM_CHANNELS];
    int unsigned      col_pos;
    int unsigned      row_pos;

    pixel_t  pending_pixels [$];
    result_t expected_averages [$];
    int      failures = 0;

    // Map a programmed dimension to the one the block really uses:
    // zero acts as one, anything past the limit saturates.
    function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > FRAME_DIM_MAX)
            return FRAME_DIM_MAX;
        return v;
    endfunction

    function automatic int unsigned clamp_to(input logic [DIM_W-1:0] v, input int unsigned lim);
        return (v > lim) ? lim : v;
    endfunction

    function automatic void clear_border_state();
        foreach (strip_sum[i])
            strip_sum[i] = '0;
        col_pos = 0;
        row_pos = 0;
    endfunction

    // Fold one pixel into the strip sums and advance the raster position.
    // Return 1 with the averaged color when this pixel closes the frame.
    function automatic bit fold_pixel_into_sums(input pixel_t p, output result_t avg);
        int unsigned     w, h, top, bot, left, right;
        logic [7:0]      chan [NUM_CHANNELS];
        bit              in_strip [NUM_STRIPS];
        longint unsigned area [NUM_STRIPS];
        longint unsigned acc;
        logic [7:0]      mean [NUM_CHANNELS];

        // Geometry is taken from the registers as they stand for this pixel,
        // so a mid-frame rewrite takes effect at once.
        w     = eff_dim(shadow_regs[REG_IMAGE_WIDTH]);
        h     = eff_dim(shadow_regs[REG_IMAGE_HEIGHT]);
        top   = clamp_to(shadow_regs[REG_TOP_STRIP_ROWS], h);
        bot   = clamp_to(shadow_regs[REG_BOTTOM_STRIP_START], h);
        left  = clamp_to(shadow_regs[REG_LEFT_STRIP_COLS], w);
        right = clamp_to(shadow_regs[REG_RIGHT_STRIP_START], w);
        avg   = '0;

        chan[0] = p.red;
        chan[1] = p.green;
        chan[2] = p.blue;
        chan[3] = p.alpha;

        if (p.frame_start)
            clear_border_state();

        in_strip[STRIP_TOP]    = row_pos < top;
        in_strip[STRIP_RIGHT]  = col_pos >= right;
        in_strip[STRIP_BOTTOM] = row_pos >= bot;
        in_strip[STRIP_LEFT]   = col_pos < left;

        for (int s = 0; s < NUM_STRIPS; s++)
            if (in_strip[s])
                for (int c = 0; c < NUM_CHANNELS; c++)
                    strip_sum[s * NUM_CHANNELS + c] += chan[c];

        if (col_pos + 1 < w)
        begin
            col_pos++;
            return 1'b0;
        end
        col_pos = 0;
        if (row_pos + 1 < h)
        begin
            row_pos++;
            return 1'b0;
        end

        // Frame closed: per-strip pixel counts, empty strips divide by one.
        area[STRIP_TOP]    = longint'(top) * w;
        area[STRIP_RIGHT]  = longint'(h) * (w - right);
        area[STRIP_BOTTOM] = longint'(h - bot) * w;
        area[STRIP_LEFT]   = longint'(left) * h;
        for (int s = 0; s < NUM_STRIPS; s++)
            if (area[s] == 0)
                area[s] = 1;

        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            acc = 0;
            for (int s = 0; s < NUM_STRIPS; s++)
                acc += longint'(strip_sum[s * NUM_CHANNELS + c]) / area[s];
            mean[c] = 8'(acc / 4);
        end
        avg.avg_red   = mean[0];
        avg.avg_green = mean[1];
        avg.avg_blue  = mean[2];
        avg.avg_alpha = mean[3];

        clear_border_state();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Pixel driver: pop pending pixels in bursts with random gaps. Hold the
    // payload while stalled; only move on once the transaction completes.
    // ------------------------------------------------------------------
    int      burst_left = 0;
    int      gap_left   = 0;
    result_t predicted;

    always @(posedge clk)
    begin
        // The pixel on the bus completes here; predict its effect now.
        if (pix_valid && !pix_stall)
        begin
            if (fold_pixel_into_sums(pix, predicted))
                expected_averages.push_back(predicted);
        end

        if (!pix_valid || !pix_stall)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                pix_valid <= 1'b0;
            end
            else if (pending_pixels.size() > 0)
            begin
                pix       <= pending_pixels.pop_front();
                pix_valid <= 1'b1;
                if (burst_left > 1)
                begin
                    burst_left--;
                end
                else
                begin
                    // Mix long unbroken runs with short choppy bursts.
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 300)
                                                             : $urandom_range(1, 12);
                    gap_left   = $urandom_range(0, 6);
                end
            end
            else
            begin
                pix_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: check each completed result transaction against the
    // oldest prediction, and drive the receiver's stall pattern.
    // ------------------------------------------------------------------
    int          long_hold_requests = 0;
    int          long_holds_served  = 0;
    int          hold_left          = 0;
    int          stall_mode         = STALL_NONE;
    int          mode_left          = 0;
    int unsigned stall_period       = 2;
    int unsigned stall_duty         = 1;
    int unsigned pattern_phase      = 0;
    result_t     oldest;

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            failures++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (res_valid && !res_stall)
        begin
            if (expected_averages.size() == 0)
            begin
                $error("result transaction with nothing expected: %h", res);
                failures++;
            end
            else
            begin
                oldest = expected_averages.pop_front();
                check_field("avg_red",   oldest.avg_red,   res.avg_red);
                check_field("avg_green", oldest.avg_green, res.avg_green);
                check_field("avg_blue",  oldest.avg_blue,  res.avg_blue);
                check_field("avg_alpha", oldest.avg_alpha, res.avg_alpha);
            end
        end

        // Start a long hold-off when one is requested; count it here.
        if (hold_left == 0 && long_holds_served != long_hold_requests)
        begin
            long_holds_served++;
            hold_left = LONG_HOLD_CYCLES;
        end

        if (mode_left == 0)
        begin
            stall_mode   = $urandom_range(STALL_NONE, STALL_HEAVY);
            mode_left    = $urandom_range(50, 400);
            stall_period = $urandom_range(2, 9);
            stall_duty   = $urandom_range(1, stall_period - 1);
        end
        mode_left--;
        pattern_phase++;

        if (hold_left > 0)
        begin
            hold_left--;
            res_stall <= 1'b1;
        end
        else
        begin
            case (stall_mode)
                STALL_NONE:     res_stall <= 1'b0;
                STALL_LIGHT:    res_stall <= ($urandom_range(0, 3) == 0);
                STALL_PERIODIC: res_stall <= ((pattern_phase % stall_period) < stall_duty);
                default:        res_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Write one register, mirroring it into the shadow copy. Out-of-map
    // indexes go to the block but leave the shadow untouched.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx < NUM_REGS)
            shadow_regs[idx] = value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Wait until every pending pixel is taken and every result is in, then
    // let the divider settle in case a partial frame is still in flight.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_pixels.size() != 0 || pix_valid || expected_averages.size() != 0);
        repeat (DIVIDE_LATENCY) @(negedge clk);
    endtask

    function automatic pixel_t make_pixel(input logic [7:0] r, g, b, a, input logic start);
        pixel_t p;
        p.red         = r;
        p.green       = g;
        p.blue        = b;
        p.alpha       = a;
        p.frame_start = start;
        return p;
    endfunction

    function automatic pixel_t random_pixel(input logic start);
        return make_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), start);
    endfunction

    // Boundary register value: mostly inside or just past the frame, with
    // zero and the all-ones extreme mixed in.
    function automatic logic [DIM_W-1:0] random_boundary(input int unsigned lim);
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return DIM_W'($urandom_range(0, lim + 1));
    endfunction

    // Queue whole frames for the current geometry. Noisy frames start with a
    // random frame_start and may restart mid-way; a ragged tail cuts the last
    // frame short so the next setting lands mid-frame.
    task automatic queue_frames(input int frames, input bit noisy, input bit ragged_end,
                                inout int unsigned tally);
        int unsigned area;
        int unsigned count;
        logic        start;
        area = eff_dim(shadow_regs[REG_IMAGE_WIDTH]) * eff_dim(shadow_regs[REG_IMAGE_HEIGHT]);
        for (int f = 0; f < frames; f++)
        begin
            count = area;
            if (ragged_end && f == frames - 1 && area > 1)
                count = $urandom_range(1, area - 1);
            for (int unsigned i = 0; i < count; i++)
            begin
                if (!noisy)
                    start = (i == 0);
                else if (i == 0)
                    start = 1'($urandom_range(0, 1));
                else
                    start = ($urandom_range(0, 39) == 0);
                pending_pixels.push_back(random_pixel(start));
            end
            tally += count;
        end
    endtask

    // A short run at an oversized geometry, strip bounds random; then shrink
    // the saturated dimension to one past the raster position so one more pixel
    // closes the frame.
    task automatic extreme_frame(input logic [DIM_W-1:0] w_val, input logic [DIM_W-1:0] h_val,
                                 input int unsigned run, inout int unsigned tally);
        write_reg(REG_IMAGE_WIDTH, w_val);
        write_reg(REG_IMAGE_HEIGHT, h_val);
        write_reg(REG_TOP_STRIP_ROWS,     random_boundary(eff_dim(h_val)));
        write_reg(REG_BOTTOM_STRIP_START, random_boundary(eff_dim(h_val)));
        write_reg(REG_LEFT_STRIP_COLS,    random_boundary(eff_dim(w_val)));
        write_reg(REG_RIGHT_STRIP_START,  random_boundary(eff_dim(w_val)));
        for (int unsigned i = 0; i < run; i++)
            pending_pixels.push_back(random_pixel(i == 0));
        tally += run + 1;
        wait_drained();
        if (eff_dim(w_val) > 1)
            write_reg(REG_IMAGE_WIDTH, DIM_W'(run + 1));
        else
            write_reg(REG_IMAGE_HEIGHT, DIM_W'(run + 1));
        pending_pixels.push_back(random_pixel(1'b0));
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    int unsigned      directed_items = 0;
    int unsigned      random_items   = 0;
    int unsigned      pick_w;
    int unsigned      pick_h;
    logic [DIM_W-1:0] reg_vals [NUM_REGS];

    initial
    begin
        // Mirror the block's reset state.
        shadow_regs[REG_IMAGE_WIDTH]        = 1;
        shadow_regs[REG_IMAGE_HEIGHT]       = 1;
        shadow_regs[REG_TOP_STRIP_ROWS]     = 0;
        shadow_regs[REG_BOTTOM_STRIP_START] = 0;
        shadow_regs[REG_LEFT_STRIP_COLS]    = 0;
        shadow_regs[REG_RIGHT_STRIP_START]  = 0;
        clear_border_state();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset geometry is 1x1: every pixel is a frame of its own.
        pending_pixels.push_back(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
        pending_pixels.push_back(make_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
        pending_pixels.push_back(make_pixel(8'hAA, 8'h55, 8'h01, 8'h80, 1'b0));
        wait_drained();

        // Small frame with one-pixel strips so corners land in two strips.
        write_reg(REG_IMAGE_WIDTH, 13'd3);
        write_reg(REG_IMAGE_HEIGHT, 13'd2);
        write_reg(REG_TOP_STRIP_ROWS, 13'd1);
        write_reg(REG_BOTTOM_STRIP_START, 13'd1);
        write_reg(REG_LEFT_STRIP_COLS, 13'd1);
        write_reg(REG_RIGHT_STRIP_START, 13'd2);
        pending_pixels.push_back(make_pixel(8'hFF, 8'h00, 8'h80, 8'h7F, 1'b1));
        pending_pixels.push_back(make_pixel(8'h01, 8'hFE, 8'hFF, 8'h00, 1'b0));
        pending_pixels.push_back(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0));
        pending_pixels.push_back(make_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
        pending_pixels.push_back(make_pixel(8'h10, 8'h20, 8'h30, 8'h40, 1'b0));
        pending_pixels.push_back(make_pixel(8'hFF, 8'h80, 8'h01, 8'hFF, 1'b0));
        wait_drained();

        // Zero dimensions act as one; every boundary far past the frame.
        write_reg(REG_IMAGE_WIDTH, '0);
        write_reg(REG_IMAGE_HEIGHT, '0);
        write_reg(REG_TOP_STRIP_ROWS, '1);
        write_reg(REG_BOTTOM_STRIP_START, '1);
        write_reg(REG_LEFT_STRIP_COLS, '1);
        write_reg(REG_RIGHT_STRIP_START, '1);
        pending_pixels.push_back(make_pixel(8'hFF, 8'h7F, 8'h80, 8'h01, 1'b0));
        pending_pixels.push_back(make_pixel(8'hC3, 8'h3C, 8'hFF, 8'hFE, 1'b1));
        wait_drained();

        // Abandon a frame half-way with frame_start and run a clean one.
        write_reg(REG_IMAGE_WIDTH, 13'd2);
        write_reg(REG_IMAGE_HEIGHT, 13'd2);
        write_reg(REG_TOP_STRIP_ROWS, 13'd1);
        write_reg(REG_BOTTOM_STRIP_START, 13'd1);
        write_reg(REG_LEFT_STRIP_COLS, 13'd1);
        write_reg(REG_RIGHT_STRIP_START, 13'd1);
        pending_pixels.push_back(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
        pending_pixels.push_back(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0));
        pending_pixels.push_back(make_pixel(8'h12, 8'h34, 8'h56, 8'h78, 1'b1));
        pending_pixels.push_back(make_pixel(8'h9A, 8'hBC, 8'hDE, 8'hF0, 1'b0));
        pending_pixels.push_back(make_pixel(8'h0F, 8'hF0, 8'h00, 8'hFF, 1'b0));
        pending_pixels.push_back(make_pixel(8'h80, 8'h40, 8'h20, 8'h10, 1'b0));
        wait_drained();

        // Shrink the frame under the raster position: the next pixel must
        // close both the row and the frame.
        write_reg(REG_IMAGE_WIDTH, 13'd4);
        write_reg(REG_IMAGE_HEIGHT, 13'd4);
        queue_frames(1, 1'b0, 1'b0, directed_items);
        pending_pixels = pending_pixels[0:5];
        wait_drained();
        write_reg(REG_IMAGE_WIDTH, 13'd2);
        write_reg(REG_IMAGE_HEIGHT, 13'd1);
        pending_pixels.push_back(make_pixel(8'hFE, 8'h01, 8'h7F, 8'h80, 1'b0));
        wait_drained();

        // Back-pressure: hold results off long enough that the output
        // register and the divider both fill and the pixel side stalls.
        write_reg(REG_IMAGE_WIDTH, 13'd2);
        write_reg(REG_IMAGE_HEIGHT, 13'd2);
        long_hold_requests++;
        queue_frames(40, 1'b0, 1'b0, directed_items);
        wait_drained();

        // Oversized width, then oversized height.
        extreme_frame('1, '0, 150, directed_items);
        extreme_frame(13'd1, 13'd4096, 100, directed_items);

        // Random geometry and strip settings, mostly well-formed frames with
        // restarts and cut-short frames mixed in.
        while (random_items < RANDOM_ITEMS)
        begin
            pick_w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
            pick_h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
            reg_vals[REG_IMAGE_WIDTH]        = DIM_W'(pick_w);
            reg_vals[REG_IMAGE_HEIGHT]       = DIM_W'(pick_h);
            reg_vals[REG_TOP_STRIP_ROWS]     = random_boundary(eff_dim(DIM_W'(pick_h)));
            reg_vals[REG_BOTTOM_STRIP_START] = random_boundary(eff_dim(DIM_W'(pick_h)));
            reg_vals[REG_LEFT_STRIP_COLS]    = random_boundary(eff_dim(DIM_W'(pick_w)));
            reg_vals[REG_RIGHT_STRIP_START]  = random_boundary(eff_dim(DIM_W'(pick_w)));
            // Skip some writes so old values carry over between settings.
            for (int r = 0; r < NUM_REGS; r++)
                if ($urandom_range(0, 4) != 0)
                    write_reg(CFG_IDX_W'(r), reg_vals[r]);
            if ($urandom_range(0, 2) == 0)
                write_reg($urandom_range(0, 1) ? SPARE_INDEX_HI : SPARE_INDEX_LO,
                          DIM_W'($urandom));
            queue_frames($urandom_range(1, 12), 1'b1, $urandom_range(0, 3) == 0,
                         random_items);
            wait_drained();
        end

        wait_drained();
        if (failures == 0 && expected_averages.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog: generous bound on the slowest legal run.
    initial
    begin
        #(WATCHDOG_NS);
        $display("FAILURE");
        $finish;
    end

endmodule
